FILE: sv/connected_component_labeler_macros.svh
// Assertion helpers used by the checker file.
`ifndef CONNECTED_COMPONENT_LABELER_MACROS_SVH
`define CONNECTED_COMPONENT_LABELER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccl assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccl assertion failed");

`endif

FILE: sv/ccl_pkg.sv
package ccl_pkg;

    localparam int unsigned VTX_W            = 6;
    localparam int unsigned CNUM_W           = 7;
    localparam int unsigned CFG_W            = 7;
    localparam int unsigned DEF_MAX_VERTICES = 64;

    localparam logic [CFG_W-1:0] VCOUNT_RESET = 7'd64;

    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_FINISH   = 1'b1;

    // Strobes from the controller to the datapath.
    typedef struct packed {
        logic load_edge;
        logic edge_wr_a;
        logic edge_wr_b;
        logic scan_clr;
        logic scan_inc;
        logic walk_start;
        logic comp_done;
        logic pop;
        logic row_rd;
        logic fresh_ld;
        logic push;
        logic label_rd;
        logic out_ld;
        logic clear;
    } t_dp_cmd;

    // Conditions reported back to the controller.
    typedef struct packed {
        logic is_finish;
        logic edge_ok;
        logic scan_end;
        logic scan_visited;
        logic sp_zero;
        logic fresh_zero;
        logic out_free;
    } t_dp_status;

endpackage

FILE: sv/ccl_ctrl.sv
module ccl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output ccl_pkg::t_dp_cmd     o_cmd,
    input  ccl_pkg::t_dp_status  i_status
);
    import ccl_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_EDGE_A  = 11'b000_0000_0010,
        S_EDGE_B  = 11'b000_0000_0100,
        S_SCAN    = 11'b000_0000_1000,
        S_POP     = 11'b000_0001_0000,
        S_ROW     = 11'b000_0010_0000,
        S_FRESH   = 11'b000_0100_0000,
        S_PUSH    = 11'b000_1000_0000,
        S_EMIT_RD = 11'b001_0000_0000,
        S_EMIT_WR = 11'b010_0000_0000,
        S_CLEAR   = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.is_finish) begin
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_SCAN;
                    end else if (i_status.edge_ok) begin
                        o_cmd.load_edge = 1'b1;
                        n_state         = S_EDGE_A;
                    end
                end
            end
            S_EDGE_A: begin
                o_cmd.edge_wr_a = 1'b1;
                n_state         = S_EDGE_B;
            end
            S_EDGE_B: begin
                o_cmd.edge_wr_b = 1'b1;
                n_state         = S_IDLE;
            end
            S_SCAN: begin
                if (i_status.scan_end) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_EMIT_RD;
                end else if (i_status.scan_visited) begin
                    o_cmd.scan_inc = 1'b1;
                end else begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = S_POP;
                end
            end
            S_POP: begin
                if (i_status.sp_zero) begin
                    o_cmd.comp_done = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_ROW;
                end
            end
            S_ROW: begin
                o_cmd.row_rd = 1'b1;
                n_state      = S_FRESH;
            end
            S_FRESH: begin
                o_cmd.fresh_ld = 1'b1;
                n_state        = S_PUSH;
            end
            S_PUSH: begin
                if (i_status.fresh_zero) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.push = 1'b1;
                end
            end
            S_EMIT_RD: begin
                if (i_status.scan_end) begin
                    n_state = S_CLEAR;
                end else begin
                    o_cmd.label_rd = 1'b1;
                    n_state        = S_EMIT_WR;
                end
            end
            S_EMIT_WR: begin
                if (i_status.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_EMIT_RD;
                end
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/ccl_dpath.sv
module ccl_dpath #(
    parameter int unsigned MAX_VERTICES = ccl_pkg::DEF_MAX_VERTICES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ccl_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_command,
    input  logic [ccl_pkg::VTX_W-1:0]    i_vertex_a,
    input  logic [ccl_pkg::VTX_W-1:0]    i_vertex_b,
    input  ccl_pkg::t_dp_cmd             i_cmd,
    output ccl_pkg::t_dp_status          o_status,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic [ccl_pkg::VTX_W-1:0]    o_vertex_index,
    output logic [ccl_pkg::CNUM_W-1:0]   o_component_number,
    output logic                         o_last
);
    import ccl_pkg::*;

    localparam int unsigned VW = $clog2(MAX_VERTICES);
    localparam int unsigned NW = $clog2(MAX_VERTICES + 1);

    // Configuration and effective vertex count.
    logic [CFG_W-1:0] r_vcount;
    logic [NW-1:0]    w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RESET;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_data;
        end
    end

    assign w_n = (r_vcount > CFG_W'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : r_vcount[NW-1:0];

    logic [MAX_VERTICES-1:0] w_live;
    always_comb begin
        for (int k = 0; k < MAX_VERTICES; k++) begin
            w_live[k] = (NW'(k) < w_n);
        end
    end

    // Edge endpoints.
    logic [VW-1:0] r_ea;
    logic [VW-1:0] r_eb;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_edge) begin
            r_ea <= i_vertex_a[VW-1:0];
            r_eb <= i_vertex_b[VW-1:0];
        end
    end

    // Adjacency memory; a row without its valid bit reads as zero.
    logic [MAX_VERTICES-1:0] r_adj_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_row_valid;
    logic [MAX_VERTICES-1:0] r_row_rdata;
    logic                    r_row_rvld;
    logic [MAX_VERTICES-1:0] w_row_eff;
    logic [VW-1:0]           r_stack_rdata;
    logic [VW-1:0]           w_row_raddr;
    logic                    w_row_re;
    logic [VW-1:0]           w_row_waddr;
    logic [VW-1:0]           w_row_bit;
    logic                    w_row_we;
    logic [MAX_VERTICES-1:0] w_row_wdata;

    assign w_row_eff = r_row_rvld ? r_row_rdata : '0;
    assign w_row_re  = i_cmd.load_edge | i_cmd.edge_wr_a | i_cmd.row_rd;
    assign w_row_we  = i_cmd.edge_wr_a | i_cmd.edge_wr_b;

    always_comb begin
        if (i_cmd.load_edge) begin
            w_row_raddr = i_vertex_a[VW-1:0];
        end else if (i_cmd.edge_wr_a) begin
            w_row_raddr = r_eb;
        end else begin
            w_row_raddr = r_stack_rdata;
        end
    end

    assign w_row_waddr = i_cmd.edge_wr_a ? r_ea : r_eb;
    assign w_row_bit   = i_cmd.edge_wr_a ? r_eb : r_ea;
    assign w_row_wdata = w_row_eff | (MAX_VERTICES'(1) << w_row_bit);

    always_ff @(posedge i_clk) begin
        if (w_row_we) begin
            r_adj_mem[w_row_waddr] <= w_row_wdata;
        end
        if (w_row_re) begin
            r_row_rdata <= r_adj_mem[w_row_raddr];
            r_row_rvld  <= r_row_valid[w_row_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_cmd.clear) begin
            r_row_valid <= '0;
        end else if (w_row_we) begin
            r_row_valid[w_row_waddr] <= 1'b1;
        end
    end

    // Walk state.
    logic [NW-1:0]           r_scan;
    logic [VW-1:0]           w_scan_idx;
    logic [MAX_VERTICES-1:0] r_visited;
    logic [MAX_VERTICES-1:0] r_fresh;
    logic [MAX_VERTICES-1:0] w_fresh;
    logic [MAX_VERTICES-1:0] w_lsb;
    logic [VW-1:0]           w_push_idx;
    logic [NW-1:0]           r_sp;
    logic [CNUM_W-1:0]       r_counter;

    assign w_scan_idx = r_scan[VW-1:0];
    assign w_fresh    = w_row_eff & w_live & ~r_visited;
    assign w_lsb      = r_fresh & (~r_fresh + MAX_VERTICES'(1));

    always_comb begin
        w_push_idx = '0;
        for (int k = 0; k < MAX_VERTICES; k++) begin
            if (w_lsb[k]) begin
                w_push_idx = w_push_idx | VW'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan    <= '0;
            r_visited <= '0;
            r_sp      <= '0;
            r_counter <= CNUM_W'(1);
        end else begin
            if (i_cmd.scan_clr) begin
                r_scan <= '0;
            end else if (i_cmd.scan_inc | i_cmd.comp_done | i_cmd.out_ld) begin
                r_scan <= r_scan + NW'(1);
            end

            if (i_cmd.clear) begin
                r_visited <= '0;
            end else if (i_cmd.walk_start) begin
                r_visited[w_scan_idx] <= 1'b1;
            end else if (i_cmd.fresh_ld) begin
                r_visited <= r_visited | w_fresh;
            end

            if (i_cmd.clear) begin
                r_sp <= '0;
            end else if (i_cmd.walk_start) begin
                r_sp <= NW'(1);
            end else if (i_cmd.pop) begin
                r_sp <= r_sp - NW'(1);
            end else if (i_cmd.push) begin
                r_sp <= r_sp + NW'(1);
            end

            if (i_cmd.clear) begin
                r_counter <= CNUM_W'(1);
            end else if (i_cmd.comp_done) begin
                r_counter <= r_counter + CNUM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fresh_ld) begin
            r_fresh <= w_fresh;
        end else if (i_cmd.push) begin
            r_fresh <= r_fresh & ~w_lsb;
        end
    end

    // Label and stack memories.
    logic [CNUM_W-1:0] r_label_mem [MAX_VERTICES];
    logic [CNUM_W-1:0] r_label_rdata;
    logic [VW-1:0]     r_stack_mem [MAX_VERTICES];
    logic [NW-1:0]     w_sp_dec;

    assign w_sp_dec = r_sp - NW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_label_mem[w_scan_idx] <= r_counter;
        end else if (i_cmd.push) begin
            r_label_mem[w_push_idx] <= r_counter;
        end
        if (i_cmd.label_rd) begin
            r_label_rdata <= r_label_mem[w_scan_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_stack_mem[VW'(0)] <= w_scan_idx;
        end else if (i_cmd.push) begin
            r_stack_mem[r_sp[VW-1:0]] <= w_push_idx;
        end
        if (i_cmd.pop) begin
            r_stack_rdata <= r_stack_mem[w_sp_dec[VW-1:0]];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            o_vertex_index     <= VTX_W'(r_scan);
            o_component_number <= r_label_rdata;
            o_last             <= ((NW+1)'(r_scan) + (NW+1)'(1)) == (NW+1)'(w_n);
        end
    end

    // Status back to the controller.
    always_comb begin
        o_status.is_finish    = (i_command == CMD_FINISH);
        o_status.edge_ok      = ({1'b0, i_vertex_a} < CFG_W'(w_n)) &&
                                ({1'b0, i_vertex_b} < CFG_W'(w_n));
        o_status.scan_end     = (r_scan == w_n);
        o_status.scan_visited = r_visited[w_scan_idx];
        o_status.sp_zero      = (r_sp == '0);
        o_status.fresh_zero   = (r_fresh == '0);
        o_status.out_free     = !o_out_valid || !i_out_stall;
    end

endmodule

FILE: sv/connected_component_labeler.sv
// Edge transaction: accept, update row a, update row b; an out-of-range edge is dropped on accept.
// Finish transaction: the scan starts a walk at each unvisited vertex; the walk pops a vertex,
// reads its row, loads its fresh neighbours and pushes them one at a time until the stack empties.
// Results are read and emitted; two end checks and a clear close it. Output stalls stretch emission.
// One transaction is worked at a time; the shared adjacency memory port sets the pace.
// Reset (synchronous, active low) empties the graph, sets vertex_count to 64 and the counter to 1.
module connected_component_labeler #(
    parameter int unsigned MAX_VERTICES = ccl_pkg::DEF_MAX_VERTICES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration: vertex_count
    input  logic                         i_cfg_we,
    input  logic [ccl_pkg::CFG_W-1:0]    i_cfg_data,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_command,
    input  logic [ccl_pkg::VTX_W-1:0]    i_vertex_a,
    input  logic [ccl_pkg::VTX_W-1:0]    i_vertex_b,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [ccl_pkg::VTX_W-1:0]    o_vertex_index,
    output logic [ccl_pkg::CNUM_W-1:0]   o_component_number,
    output logic                         o_last
);
    import ccl_pkg::*;

    // The controller sequences edge loading, the depth-first walk, the
    // label readout and the clearing step. It drives one-cycle strobes into
    // the datapath and branches on the status conditions it reports.
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    ccl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    // The datapath holds the adjacency matrix (one memory row per vertex,
    // a valid bit per row so clearing the matrix only resets those bits), the visited
    // marks, the label and stack memories, and the output register. The
    // output register decouples the result side: the controller only
    // waits when a new result is ready and the previous one is still held.
    ccl_dpath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_command          (i_command),
        .i_vertex_a         (i_vertex_a),
        .i_vertex_b         (i_vertex_b),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_vertex_index     (o_vertex_index),
        .o_component_number (o_component_number),
        .o_last             (o_last)
    );

endmodule

FILE: sv/ccl_checker.sv
`include "connected_component_labeler_macros.svh"

module ccl_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         i_command,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [ccl_pkg::VTX_W-1:0]    o_vertex_index,
    input logic [ccl_pkg::CNUM_W-1:0]   o_component_number,
    input logic                         o_last
);
    import ccl_pkg::*;

    // A held result stays offered.
    `CCL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // A held result keeps its payload.
    `CCL_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall,
                     $stable(o_vertex_index) && $stable(o_component_number) && $stable(o_last))

    // Component numbers start at one and never exceed the vertex limit.
    `CCL_ASSERT_NOW(a_num_range, i_clk, i_rst_n, o_out_valid,
                    (o_component_number != '0) &&
                    (o_component_number <= CNUM_W'(DEF_MAX_VERTICES)))

    // A finish transaction occupies the block on the next cycle.
    `CCL_ASSERT_NEXT(a_finish_busy, i_clk, i_rst_n,
                     i_in_valid && !o_in_stall && (i_command == CMD_FINISH), o_in_stall)

endmodule

bind connected_component_labeler ccl_checker u_ccl_checker (.*);

FILE: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ccl_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int MAXV          = DEF_MAX_VERTICES;
    localparam int IDLE_PCT      = 17;
    localparam int RANDOM_ITEMS  = 500;
    // Covers the trailing edge update and the clearing step after a finish.
    localparam int SETTLE_CYCLES = 24;
    // Outlasts a full 64-vertex walk before its first label.
    localparam int STUCK_LIMIT   = 5000;

    typedef struct packed {
        logic             command;
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
    } graph_item_t;

    typedef struct packed {
        logic [VTX_W-1:0]  vertex_index;
        logic [CNUM_W-1:0] component_number;
        logic              last;
    } vertex_label_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_we      = 1'b0;
    logic [CFG_W-1:0]  cfg_data    = '0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    logic              in_command  = CMD_ADD_EDGE;
    logic [VTX_W-1:0]  in_vertex_a = '0;
    logic [VTX_W-1:0]  in_vertex_b = '0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    logic [VTX_W-1:0]  out_vertex_index;
    logic [CNUM_W-1:0] out_component_number;
    logic              out_last;

    // Suppress idling on both channels while set.
    logic steady = 1'b0;

    graph_item_t   graph_items[$];
    vertex_label_t expected_labels[$];

    // Shadow copy of the labeler state, advanced on every accepted transaction.
    logic [MAXV-1:0]   adj_rows [MAXV] = '{default: '0};
    logic [MAXV-1:0]   visited_set     = '0;
    logic [CNUM_W-1:0] vertex_labels [MAXV];
    logic [CFG_W-1:0]  vertex_count    = VCOUNT_RESET;

    int fail_count     = 0;
    int graphs_labeled = 0;
    int edges_loaded   = 0;
    int labels_checked = 0;
    int stuck_cycles   = 0;

    connected_component_labeler u_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_command          (in_command),
        .i_vertex_a         (in_vertex_a),
        .i_vertex_b         (in_vertex_b),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_vertex_index     (out_vertex_index),
        .o_component_number (out_component_number),
        .o_last             (out_last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Vertex count as the block uses it: anything above the maximum clamps.
    function automatic int live_count();
        return (vertex_count > MAXV) ? MAXV : int'(vertex_count);
    endfunction

    // Advance the shadow graph by one transaction. An edge only sets matrix bits;
    // a finish walks the graph depth first, queues one label per vertex and clears.
    function automatic void apply_graph_item(graph_item_t item);
        int                n;
        int                sp;
        int                v;
        logic [MAXV-1:0]   live;
        logic [MAXV-1:0]   fresh;
        logic [VTX_W-1:0]  walk_stack [MAXV];
        logic [CNUM_W-1:0] next_component;
        vertex_label_t     lbl;
        n = live_count();
        if (item.command == CMD_ADD_EDGE) begin
            // Drop edges that reach past the current vertex count.
            if (item.vertex_a < n && item.vertex_b < n) begin
                adj_rows[item.vertex_a][item.vertex_b] = 1'b1;
                adj_rows[item.vertex_b][item.vertex_a] = 1'b1;
                edges_loaded++;
            end
            return;
        end
        graphs_labeled++;
        live = '0;
        for (int i = 0; i < n; i++) live[i] = 1'b1;
        next_component = CNUM_W'(1);
        // Start a new component at every unvisited vertex, lowest first.
        for (int s = 0; s < n; s++) begin
            if (!visited_set[s]) begin
                visited_set[s]    = 1'b1;
                vertex_labels[s]  = next_component;
                walk_stack[0]     = VTX_W'(s);
                sp                = 1;
                while (sp > 0) begin
                    sp--;
                    v     = int'(walk_stack[sp]);
                    // Stored edges to vertices beyond the live count are ignored.
                    fresh = adj_rows[v] & live & ~visited_set;
                    for (int u = 0; u < MAXV; u++) begin
                        if (fresh[u]) begin
                            visited_set[u]   = 1'b1;
                            vertex_labels[u] = next_component;
                            walk_stack[sp]   = VTX_W'(u);
                            sp++;
                        end
                    end
                end
                next_component++;
            end
        end
        for (int i = 0; i < n; i++) begin
            lbl.vertex_index     = VTX_W'(i);
            lbl.component_number = vertex_labels[i];
            lbl.last             = (i == n - 1);
            expected_labels.insert(expected_labels.size(), lbl);
        end
        foreach (adj_rows[i]) adj_rows[i] = '0;
        visited_set = '0;
    endfunction

    // Mostly small graphs; a few full-size and over-range counts, rarely zero.
    function automatic int pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 5)  return 0;
        if (r < 13) return 1;
        if (r < 78) return $urandom_range(2, 16);
        if (r < 93) return $urandom_range(17, 64);
        return $urandom_range(65, 127);
    endfunction

    // Write vertex_count; call only while the block is idle.
    task automatic write_count(input int value);
        @(posedge clk);
        cfg_we       <= 1'b1;
        cfg_data     <= CFG_W'(value);
        vertex_count = CFG_W'(value);
        @(posedge clk);
        cfg_we       <= 1'b0;
    endtask

    // Block until every queued transaction is accepted and every label has
    // come back, then hold off long enough for trailing edge updates to land.
    task automatic wait_idle();
        do @(negedge clk);
        while (graph_items.size() != 0 || in_valid || expected_labels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic push_edge(input int a, input int b);
        graph_items.insert(graph_items.size(),
                           graph_item_t'{CMD_ADD_EDGE, VTX_W'(a), VTX_W'(b)});
    endtask

    task automatic push_finish();
        graph_items.insert(graph_items.size(),
                           graph_item_t'{CMD_FINISH, VTX_W'(0), VTX_W'(0)});
    endtask

    // Input driver: retire the accepted transaction into the predictor, then
    // present the next queued item unless this cycle rolls an idle.
    always @(posedge clk) begin : drive_items
        logic        next_valid;
        graph_item_t item;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            next_valid = in_valid;
            if (in_valid && !in_stall) begin
                apply_graph_item('{in_command, in_vertex_a, in_vertex_b});
                next_valid = 1'b0;
            end
            // Hold the payload while stalled; only load when the slot is free.
            if (!next_valid && graph_items.size() != 0 &&
                (steady || $urandom_range(99) >= IDLE_PCT)) begin
                item        = graph_items.pop_front();
                in_command  <= item.command;
                in_vertex_a <= item.vertex_a;
                in_vertex_b <= item.vertex_b;
                next_valid  = 1'b1;
            end
            in_valid <= next_valid;
        end
    end

    // Label monitor: compare each accepted label with the oldest prediction,
    // then roll the stall for the next cycle.
    always @(posedge clk) begin : check_labels
        vertex_label_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_labels.size() == 0) begin
                    $error("unexpected label: vertex_index %0d component_number %0d last %0b",
                           out_vertex_index, out_component_number, out_last);
                    fail_count++;
                end else begin
                    want = expected_labels.pop_front();
                    labels_checked++;
                    if (out_vertex_index !== want.vertex_index) begin
                        $error("vertex_index mismatch: expected %0d, actual %0d",
                               want.vertex_index, out_vertex_index);
                        fail_count++;
                    end
                    if (out_component_number !== want.component_number) begin
                        $error("component_number mismatch: expected %0d, actual %0d",
                               want.component_number, out_component_number);
                        fail_count++;
                    end
                    if (out_last !== want.last) begin
                        $error("last mismatch: expected %0b, actual %0b",
                               want.last, out_last);
                        fail_count++;
                    end
                end
            end
            out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog: abort when neither channel has moved a transaction for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("connected_component_labeler regression: fail");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : stimulus
        int random_items;
        int phase;
        int n;
        int edge_total;
        int a;
        int b;
        logic clustered;
        random_items = 0;
        phase        = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Full-size graph: extreme endpoints, self loops and a short chain.
        write_count(64);
        push_edge(0, 63);
        push_edge(63, 62);
        push_edge(5, 5);
        push_edge(63, 63);
        push_edge(1, 2);
        push_finish();
        wait_idle();

        // Count above the maximum clamps to a full 64-vertex graph.
        write_count(127);
        push_edge(62, 63);
        push_finish();
        wait_idle();

        // Single vertex: the edge to vertex 1 is out of range, the self loop is kept.
        write_count(1);
        push_edge(0, 1);
        push_edge(0, 0);
        push_finish();
        wait_idle();

        // Zero vertices: every edge is dropped and the finish emits nothing.
        write_count(0);
        push_edge(0, 0);
        push_finish();
        wait_idle();

        // Shrink the count after loading so a stored edge falls out of range.
        write_count(10);
        push_edge(3, 9);
        push_edge(9, 12);
        push_edge(2, 3);
        wait_idle();
        write_count(4);
        push_finish();
        wait_idle();

        // Random graphs, mostly well formed, some with noise edges mixed in.
        while (random_items < RANDOM_ITEMS) begin
            steady = (phase >= 10 && phase < 18);
            if ($urandom_range(99) >= 15) write_count(pick_count());
            n          = live_count();
            edge_total = (n == 0) ? $urandom_range(0, 3)
                                  : $urandom_range(0, (n + n / 2 > 48) ? 48 : n + n / 2);
            // Clustered graphs link nearby vertices to build long components.
            clustered  = ($urandom_range(1) == 1);
            repeat (edge_total) begin
                if (n == 0 || $urandom_range(99) < 10) begin
                    a = $urandom_range(63);
                    b = $urandom_range(63);
                end else begin
                    a = $urandom_range(n - 1);
                    b = clustered ? (a + $urandom_range(1, 3)) % n : $urandom_range(n - 1);
                end
                random_items++;
                push_edge(a, b);
            end
            if (n > 0 && $urandom_range(99) < 15) begin
                wait_idle();
                write_count(pick_count());
            end
            push_finish();
            random_items++;
            // Occasionally finish again right away on the freshly cleared graph.
            if ($urandom_range(99) < 10) begin
                push_finish();
                random_items++;
            end
            wait_idle();
            phase++;
        end
        steady = 1'b0;
        wait_idle();

        $display("labeled %0d graphs from %0d stored edges, %0d vertex labels checked",
                 graphs_labeled, edges_loaded, labels_checked);
        $display("vertex counts from 0 to 127 used, including changes after loading");
        if (fail_count == 0 && expected_labels.size() == 0) begin
            $display("connected_component_labeler regression: pass");
        end else begin
            $display("connected_component_labeler regression: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/ccl_pkg.sv
sv/ccl_ctrl.sv
sv/ccl_dpath.sv
sv/connected_component_labeler.sv
sv/ccl_checker.sv
test/tb.sv
